FILE: sv/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int MODE_W   = 3;
	localparam int ID_W     = 16;
	localparam int SLICE_W  = 16;
	localparam int TICK_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

	// command codes
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_YIELD  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	// register index on the config port
	localparam logic REG_SLICE_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} state_t;

	// queue read address select
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_IDX,
		RD_IDX1
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    add;
		logic    full_err;
		logic    nf_err;
		logic    tick;
		logic    drop_run;
		logic    pop;
		logic    idx_inc;
		logic    shift_wr;
		logic    shrink;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              run_valid;
		logic              fill_zero;
		logic              full;
		logic              slice_le1;
		logic              match;
		logic              scan_end;
	} dp_stat_t;

	// (base + off) modulo the queue depth, off never above the depth
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
			input logic [FILL_W-1:0] off);
		logic [FILL_W:0] sum;
		sum = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
		if (sum >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (FILL_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: sv/rrts_ctrl.sv
`timescale 1ns / 1ps
module rrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rrts_pkg::dp_stat_t stat,
	output logic              busy,
	output logic              done,
	output rrts_pkg::dp_cmd_t  cmd
);
	import rrts_pkg::*;

	state_t state_q, state_nxt;

	// a reschedule only does anything with a task waiting
	logic resched_go;

	always_comb begin
		unique case (stat.mode)
			MODE_TICK:  resched_go = stat.run_valid && stat.slice_le1 && !stat.fill_zero;
			MODE_YIELD: resched_go = stat.run_valid && !stat.fill_zero;
			MODE_SCHED,
			MODE_BLOCK: resched_go = !stat.fill_zero;
			default:    resched_go = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.mode == MODE_REMOVE) begin
					state_nxt = stat.fill_zero ? ST_DONE : ST_CMP;
				end else begin
					state_nxt = resched_go ? ST_POP : ST_DONE;
				end
			end
			ST_POP: state_nxt = ST_DONE;
			ST_CMP: begin
				if (stat.match) begin
					state_nxt = ST_SH_RD;
				end else if (stat.scan_end) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_CMP;
				end
			end
			ST_SH_RD: state_nxt = stat.scan_end ? ST_DONE : ST_SH_WR;
			ST_SH_WR: state_nxt = ST_SH_RD;
			ST_DONE:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd    = '0;
		cmd.rd_sel = RD_HEAD;
		busy   = (state_q != ST_IDLE);
		done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				unique case (stat.mode)
					MODE_ADD: begin
						cmd.add      = !stat.full;
						cmd.full_err = stat.full;
					end
					MODE_REMOVE: begin
						cmd.nf_err = stat.fill_zero;
						cmd.rd_en  = !stat.fill_zero;
						cmd.rd_sel = RD_IDX;
					end
					MODE_TICK: begin
						cmd.tick  = 1'b1;
						cmd.rd_en = resched_go;
					end
					MODE_BLOCK: begin
						cmd.drop_run = 1'b1;
						cmd.rd_en    = resched_go;
					end
					default: begin
						cmd.rd_en = resched_go;
					end
				endcase
			end
			ST_POP: begin
				cmd.pop = 1'b1;
			end
			ST_CMP: begin
				if (!stat.match) begin
					cmd.nf_err  = stat.scan_end;
					cmd.idx_inc = !stat.scan_end;
					cmd.rd_en   = !stat.scan_end;
					cmd.rd_sel  = RD_IDX1;
				end
			end
			ST_SH_RD: begin
				cmd.shrink = stat.scan_end;
				cmd.rd_en  = !stat.scan_end;
				cmd.rd_sel = RD_IDX1;
			end
			ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/rrts_dpath.sv
`timescale 1ns / 1ps
module rrts_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrts_pkg::dp_cmd_t               cmd,
	input  logic [rrts_pkg::MODE_W-1:0]     mode,
	input  logic [rrts_pkg::ID_W-1:0]       task_id,
	input  logic [rrts_pkg::SLICE_W-1:0]    slice_length,
	output rrts_pkg::dp_stat_t              stat,
	output logic                            switched,
	output logic                            running_valid,
	output logic [rrts_pkg::ID_W-1:0]       running_id,
	output logic [rrts_pkg::COUNT_W-1:0]    ready_count,
	output logic [rrts_pkg::STATUS_W-1:0]   status,
	output logic [rrts_pkg::TICK_W-1:0]     tick_total
);
	import rrts_pkg::*;

	// ready queue storage, read data registered
	logic [ID_W-1:0] ready_mem [QUEUE_DEPTH];
	logic [ID_W-1:0] rd_data_q;

	logic [MODE_W-1:0]   mode_q;
	logic [ID_W-1:0]     task_id_q;
	logic [IDX_W-1:0]    head_q;
	logic [FILL_W-1:0]   fill_q;
	logic [IDX_W-1:0]    idx_q;
	logic                run_valid_q;
	logic [ID_W-1:0]     run_id_q;
	logic [SLICE_W-1:0]  slice_q;
	logic [TICK_W-1:0]   tick_q;
	logic                switched_q;
	logic [STATUS_W-1:0] status_q;

	logic [FILL_W-1:0] idx_ext;
	logic [FILL_W-1:0] idx_ext1;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ID_W-1:0]   wr_data;

	assign idx_ext  = FILL_W'(idx_q);
	assign idx_ext1 = idx_ext + FILL_W'(1);

	// read address
	always_comb begin
		unique case (cmd.rd_sel)
			RD_HEAD: rd_addr = head_q;
			RD_IDX:  rd_addr = wrap_add(head_q, idx_ext);
			RD_IDX1: rd_addr = wrap_add(head_q, idx_ext1);
			default: rd_addr = head_q;
		endcase
	end

	// write port: append, requeue of the preempted task, or shift down
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wrap_add(head_q, fill_q);
		wr_data = task_id_q;
		if (cmd.add) begin
			wr_en = 1'b1;
		end else if (cmd.pop && run_valid_q) begin
			wr_en   = 1'b1;
			wr_data = run_id_q;
		end else if (cmd.shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = wrap_add(head_q, idx_ext);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ready_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= ready_mem[rd_addr];
		end
	end

	// captured command beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode;
			task_id_q <= task_id;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			slice_q     <= '0;
			tick_q      <= '0;
			switched_q  <= 1'b0;
			status_q    <= STATUS_OK;
		end else begin
			if (cmd.load) begin
				idx_q      <= '0;
				switched_q <= 1'b0;
				status_q   <= STATUS_OK;
			end
			if (cmd.add) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.full_err) begin
				status_q <= STATUS_FULL;
			end
			if (cmd.nf_err) begin
				status_q <= STATUS_NOT_FOUND;
			end
			if (cmd.tick) begin
				tick_q <= tick_q + TICK_W'(1);
				if (run_valid_q && slice_q != '0) begin
					slice_q <= slice_q - SLICE_W'(1);
				end
			end
			if (cmd.drop_run) begin
				run_valid_q <= 1'b0;
			end
			// pop the head; a running task goes back in at the tail
			if (cmd.pop) begin
				head_q      <= wrap_add(head_q, FILL_W'(1));
				run_valid_q <= 1'b1;
				run_id_q    <= rd_data_q;
				slice_q     <= slice_length;
				switched_q  <= 1'b1;
				if (!run_valid_q) begin
					fill_q <= fill_q - FILL_W'(1);
				end
			end
			if (cmd.idx_inc || cmd.shift_wr) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.shrink) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// status to the controller
	assign stat.mode      = mode_q;
	assign stat.run_valid = run_valid_q;
	assign stat.fill_zero = (fill_q == '0);
	assign stat.full      = (fill_q >= FILL_W'(QUEUE_DEPTH));
	assign stat.slice_le1 = (slice_q <= SLICE_W'(1));
	assign stat.match     = (rd_data_q == task_id_q);
	assign stat.scan_end  = (idx_ext1 >= fill_q);

	// result beat
	assign switched      = switched_q;
	assign running_valid = run_valid_q;
	assign running_id    = run_valid_q ? run_id_q : '0;
	assign ready_count   = COUNT_W'(fill_q);
	assign status        = status_q;
	assign tick_total    = tick_q;

endmodule

FILE: sv/round_robin_task_scheduler.sv
`timescale 1ns / 1ps
// Channel   Handshake                        Beat
// command   start / busy                     mode, task_id
// result    done (one-cycle strobe)          switched, running_valid, running_id,
//                                            ready_count, status, tick_total
// config    psel, penable, pwrite, pready    paddr, pwdata, prdata (slice_length)
//
// A command that needs no queue search (add, tick, yield, schedule, block) runs
// from its start cycle through EXEC to DONE; a reschedule adds a POP state for
// the pop. Remove walks the queue through its single read port: it compares each
// entry in turn up to the hit, then shifts every later entry down with a read and
// a write, and ends in a closing SH_RD step that shrinks the queue; a miss compares all.
// arst_n clears all control state; queue entries are undefined until written.
// Results are shown for one cycle with done; the receiver cannot stall.
module round_robin_task_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rrts_pkg::MODE_W-1:0]     mode,
	input  logic [rrts_pkg::ID_W-1:0]       task_id,
	output logic                            done,
	output logic                            switched,
	output logic                            running_valid,
	output logic [rrts_pkg::ID_W-1:0]       running_id,
	output logic [rrts_pkg::COUNT_W-1:0]    ready_count,
	output logic [rrts_pkg::STATUS_W-1:0]   status,
	output logic [rrts_pkg::TICK_W-1:0]     tick_total,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rrts_pkg::ADDR_W-1:0]     paddr,
	input  logic [rrts_pkg::DATA_W-1:0]     pwdata,
	output logic [rrts_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import rrts_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [SLICE_W-1:0] slice_length_q;
	logic              cfg_wr;

	// config register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_length_q <= SLICE_RESET;
		end else if (cfg_wr && paddr[2] == REG_SLICE_LENGTH) begin
			slice_length_q <= pwdata[SLICE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SLICE_LENGTH) ? DATA_W'(slice_length_q) : '0;

	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	rrts_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.task_id       (task_id),
		.slice_length  (slice_length_q),
		.stat          (stat),
		.switched      (switched),
		.running_valid (running_valid),
		.running_id    (running_id),
		.ready_count   (ready_count),
		.status        (status),
		.tick_total    (tick_total)
	);

endmodule
